>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes of the stable sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // priority range
  localparam logic [2:0] PRIO_MIN = 3'd1;
  localparam logic [2:0] PRIO_MAX = 3'd4;

  // request item
  typedef struct packed {
    logic        req_type;
    logic [15:0] entry_tag;
    logic [2:0]  entry_priority;
  } req_t;

  // response item
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [2:0]  out_priority;
    logic [4:0]  occupancy;
  } rsp_t;

  // contents of one queue slot
  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  prio;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic        push;
    logic        pop;
    logic [15:0] tag;
    logic [2:0]  prio;
  } cmd_t;

endpackage

>>> hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the shift-insert queue with its local priority compare
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic          clk,
  input  spq_pkg::cmd_t cmd,
  input  logic          occupied,
  input  logic          left_ge,
  input  spq_pkg::slot_t left_slot,
  input  spq_pkg::slot_t right_slot,
  output spq_pkg::slot_t slot,
  output logic          ge
);

  // this slot stays ahead of the new entry
  assign ge = occupied && (slot.prio >= cmd.prio);

  // insert: keep, take new entry, or shift from the left; pop: shift from right
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (!ge) begin
        if (left_ge) begin
          slot.tag  <= cmd.tag;
          slot.prio <= cmd.prio;
        end else begin
          slot <= left_slot;
        end
      end
    end else if (cmd.pop) begin
      slot <= right_slot;
    end
  end

endmodule

>>> hdl/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue, highest priority first, FIFO among equals
// ----------------------------------------------------------------------------
// The queue takes one request per clock cycle and returns its response in the
// next cycle from an output register; a new request is taken whenever that
// register is empty or its response is being taken in the same cycle. The
// entries sit in a row of QUEUE_DEPTH cells, each comparing its own priority
// with the pushed one in parallel, so a push shifts the lower-priority tail
// one place right and a pop shifts the whole row one place left. Priorities 0
// and 5..7 are clamped to 1 and 4. Occupancy reports the low five bits of the
// entry count.
module stable_priority_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

`include "assert_macros.svh"

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic           accept;
  logic           full;
  logic           empty;
  logic           drop_push;
  logic [2:0]     prio_clamped;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  spq_pkg::cmd_t  cmd;
  spq_pkg::rsp_t  rsp_next;
  spq_pkg::slot_t slots [QUEUE_DEPTH];
  logic           ge    [QUEUE_DEPTH];

  // handshake
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign drop_push = accept && (req.req_type == spq_pkg::REQ_PUSH) && full;

  // clamp priority into range
  always_comb begin
    if (req.entry_priority < spq_pkg::PRIO_MIN) begin
      prio_clamped = spq_pkg::PRIO_MIN;
    end else if (req.entry_priority > spq_pkg::PRIO_MAX) begin
      prio_clamped = spq_pkg::PRIO_MAX;
    end else begin
      prio_clamped = req.entry_priority;
    end
  end

  // command to the cell row
  always_comb begin
    cmd.push = accept && (req.req_type == spq_pkg::REQ_PUSH) && !full;
    cmd.pop  = accept && (req.req_type == spq_pkg::REQ_POP) && !empty;
    cmd.tag  = req.entry_tag;
    cmd.prio = prio_clamped;
  end

  // entry count
  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic           occ;
    logic           lge;
    spq_pkg::slot_t lslot;
    spq_pkg::slot_t rslot;

    assign occ = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign lge   = 1'b1;
      assign lslot = '0;
    end else begin : g_body
      assign lge   = ge[i-1];
      assign lslot = slots[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rslot = '0;
    end else begin : g_inner
      assign rslot = slots[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occ),
      .left_ge    (lge),
      .left_slot  (lslot),
      .right_slot (rslot),
      .slot       (slots[i]),
      .ge         (ge[i])
    );
  end

  // response item
  always_comb begin
    rsp_next.status       = spq_pkg::STAT_OK;
    rsp_next.out_tag      = '0;
    rsp_next.out_priority = '0;
    rsp_next.occupancy    = 5'(count_next);
    if (req.req_type == spq_pkg::REQ_PUSH) begin
      if (full) begin
        rsp_next.status = spq_pkg::STAT_FULL;
      end
    end else if (empty) begin
      rsp_next.status = spq_pkg::STAT_EMPTY;
    end else begin
      rsp_next.out_tag      = slots[0].tag;
      rsp_next.out_priority = slots[0].prio;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_full_flag, clk, rst, drop_push, rsp_valid && (rsp.status == spq_pkg::STAT_FULL))
  `ASSERT_ALWAYS(a_head_sorted, clk, rst, (count < CW'(2)) || (slots[0].prio >= slots[1].prio))
  `ASSERT_NEXT(a_pop_shrinks, clk, rst, cmd.pop, count == $past(count) - CW'(1))

endmodule

>>> dv/tb_stable_priority_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue_unit
// Self-checking bench for the stable sorted priority queue
// ----------------------------------------------------------------------------
// A mirror of the queue contents predicts the response of every accepted
// request; each accepted response is compared against the oldest prediction.
// A short directed run covers empty pops, priority clamping, filling up and
// a push into a full queue. Random bursts then lean toward pushes or pops so
// the queue swings between full and empty. Both sides idle at random, the
// receiver holds off for long stretches so the block backs up, and the
// sender drains the queue of pending responses once midway.

class queue_scoreboard;
  localparam int DEPTH = 16;

  spq_pkg::slot_t mirror_slots [DEPTH];
  int             mirror_count;
  spq_pkg::rsp_t  predicted_rsp [$];
  int unsigned    mismatches;
  int unsigned    rsp_seen;

  function new();
    mirror_count = 0;
    mismatches   = 0;
    rsp_seen     = 0;
  endfunction

  // update the mirror with an accepted request and queue up its response
  function void note_request(spq_pkg::req_t r);
    spq_pkg::rsp_t e;
    logic [2:0]    p;
    int            pos;
    e              = '0;
    e.status       = spq_pkg::STAT_OK;
    p              = r.entry_priority;
    if (p < spq_pkg::PRIO_MIN) begin
      p = spq_pkg::PRIO_MIN;
    end else if (p > spq_pkg::PRIO_MAX) begin
      p = spq_pkg::PRIO_MAX;
    end
    if (r.req_type == spq_pkg::REQ_PUSH) begin
      if (mirror_count >= DEPTH) begin
        e.status = spq_pkg::STAT_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher priority
        pos = 0;
        while (pos < mirror_count && mirror_slots[pos].prio >= p) pos++;
        for (int i = mirror_count; i > pos; i--) mirror_slots[i] = mirror_slots[i - 1];
        mirror_slots[pos].tag  = r.entry_tag;
        mirror_slots[pos].prio = p;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        e.status = spq_pkg::STAT_EMPTY;
      end else begin
        e.out_tag      = mirror_slots[0].tag;
        e.out_priority = mirror_slots[0].prio;
        for (int i = 1; i < mirror_count; i++) mirror_slots[i - 1] = mirror_slots[i];
        mirror_count--;
      end
    end
    e.occupancy = mirror_count[4:0];
    predicted_rsp.push_back(e);
  endfunction

  // compare an accepted response with the oldest prediction
  function void check_response(spq_pkg::rsp_t got);
    spq_pkg::rsp_t want;
    rsp_seen++;
    if (predicted_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected response: status %0d tag %h prio %0d occ %0d",
                 got.status, got.out_tag, got.out_priority, got.occupancy);
      end
      return;
    end
    want = predicted_rsp.pop_front();
    if (got.status !== want.status || got.out_tag !== want.out_tag ||
        got.out_priority !== want.out_priority || got.occupancy !== want.occupancy) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at response %0d: expected status %0d tag %h prio %0d occ %0d,",
                 rsp_seen, want.status, want.out_tag, want.out_priority, want.occupancy);
        $display("  got status %0d tag %h prio %0d occ %0d",
                 got.status, got.out_tag, got.out_priority, got.occupancy);
      end
    end
  endfunction
endclass

module tb_stable_priority_queue_unit;

  localparam int DEPTH       = 16;
  localparam int LIMIT       = 500000;
  localparam int RANDOM_ITEMS = 1030;

  logic          clk = 1'b0;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  spq_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  spq_pkg::rsp_t rsp;

  int unsigned     cycle_count = 0;
  bit              stimulus_random = 0;
  queue_scoreboard sb = new();

  stable_priority_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #10 clk = ~clk;

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // idle length: mostly short, a few long, none during quiet stretches
  function automatic int pick_gap();
    int r;
    if ((cycle_count % 600) < 150) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic spq_pkg::req_t make_req(logic kind, logic [15:0] tag, logic [2:0] prio);
    spq_pkg::req_t r;
    r.req_type       = kind;
    r.entry_tag      = tag;
    r.entry_priority = prio;
    return r;
  endfunction

  // offer one item after a random gap and hold it until accepted
  task automatic send_request(spq_pkg::req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      req       <= spq_pkg::req_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  // stop offering until every predicted response has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.predicted_rsp.size() != 0) @(posedge clk);
  endtask

  // receiver: take responses, stall at random, hold off long twice
  initial begin
    int stall_left;
    int long_holds;
    int g;
    stall_left = 0;
    long_holds = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (rst) begin
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (stimulus_random && long_holds < 2 && sb.rsp_seen >= 300 + 450 * long_holds) begin
        long_holds++;
        stall_left = 150;
        rsp_ready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          stall_left = g - 1;
          rsp_ready <= 1'b0;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  // sender and end of run
  initial begin
    int            push_pct;
    spq_pkg::req_t r;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, clamped priorities, fill up, push into full
    send_request(make_req(spq_pkg::REQ_POP,  16'hFFFF, 3'd7));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h0000, 3'd1));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'hFFFF, 3'd4));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h1111, 3'd0));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h2222, 3'd5));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h3333, 3'd2));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h4444, 3'd3));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h5555, 3'd6));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h6666, 3'd7));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h7777, 3'd2));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h8888, 3'd3));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h9999, 3'd1));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'hAAAA, 3'd4));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'hBBBB, 3'd2));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'hCCCC, 3'd3));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'hDDDD, 3'd1));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'hEEEE, 3'd4));
    send_request(make_req(spq_pkg::REQ_PUSH, 16'h1234, 3'd4));
    send_request(make_req(spq_pkg::REQ_POP,  16'h0000, 3'd0));
    send_request(make_req(spq_pkg::REQ_POP,  16'h5A5A, 3'd3));
    send_request(make_req(spq_pkg::REQ_POP,  16'hFFFF, 3'd7));
    send_request(make_req(spq_pkg::REQ_POP,  16'hA5A5, 3'd4));
    wait_drained();

    // random bursts, each leaning toward pushes, pops or neither
    stimulus_random = 1;
    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 85;
          1: push_pct = 15;
          2: push_pct = 50;
          default: push_pct = 65;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();
      r.req_type  = ($urandom_range(0, 99) < push_pct) ? spq_pkg::REQ_PUSH : spq_pkg::REQ_POP;
      r.entry_tag = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        r.entry_priority = 3'($urandom_range(0, 7));
      end else begin
        r.entry_priority = 3'($urandom_range(1, 4));
      end
      send_request(r);
    end
    wait_drained();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.predicted_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
